/* hdl/multi_channel_byte_fifo_pool_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the byte FIFO pool
// Concurrent checks, clocked and disabled by the given reset.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_BYTE_FIFO_POOL_TOP_ASSERT_SVH
`define MULTI_CHANNEL_BYTE_FIFO_POOL_TOP_ASSERT_SVH

// same-cycle implication
`define MCBFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcbfp check failed");

// next-cycle implication
`define MCBFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcbfp check failed");

`endif

/* hdl/mcbfp_pkg.sv */
// ---------------------------------------------------------------------------
// mcbfp_pkg
// Sizes, opcodes and status codes shared by the byte FIFO pool.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcbfp_pkg;

   localparam int NUM_CHANNELS  = 16;
   localparam int CHANNEL_BYTES = 1024;

   localparam int CH_FIELD_W  = 4;
   localparam int LEN_W       = 10;
   localparam int DATA_W      = 8;
   localparam int OP_W        = 2;
   localparam int ST_W        = 3;

   localparam int CH_IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int PTR_W       = $clog2(CHANNEL_BYTES);
   localparam int CNT_W       = $clog2(CHANNEL_BYTES + 1);
   localparam int STORE_DEPTH = NUM_CHANNELS * CHANNEL_BYTES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic [OP_W-1:0] OP_OPEN  = 2'd0;
   localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   localparam logic [ST_W-1:0] ST_OK         = 3'd0;
   localparam logic [ST_W-1:0] ST_NO_CHANNEL = 3'd1;
   localparam logic [ST_W-1:0] ST_NOT_OPEN   = 3'd2;
   localparam logic [ST_W-1:0] ST_NO_SPACE   = 3'd3;
   localparam logic [ST_W-1:0] ST_EMPTY      = 3'd4;

   typedef struct packed {
      logic load;
      logic execute;
   } cmd_type;

endpackage

/* hdl/mcbfp_ctrl.sv */
// ---------------------------------------------------------------------------
// mcbfp_ctrl
// Sequencer: take a word, execute it, hold the response until taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcbfp_ctrl
   import mcbfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_tready  = (state_ff == S_IDLE);
   assign rsp_tvalid  = (state_ff == S_RESP);
   assign cmd.load    = req_tvalid && req_tready;
   assign cmd.execute = (state_ff == S_EXEC);

endmodule

/* hdl/mcbfp_datapath.sv */
// ---------------------------------------------------------------------------
// mcbfp_datapath
// Channel table, ring pointers, byte store and response registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcbfp_datapath
   import mcbfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   input  logic [OP_W-1:0]       req_op,
   input  logic [CH_FIELD_W-1:0] req_channel,
   input  logic [DATA_W-1:0]     req_write_data,
   input  logic                  req_run_first,
   input  logic [LEN_W-1:0]      req_run_length,
   output logic [ST_W-1:0]       rsp_status,
   output logic [CH_FIELD_W-1:0] rsp_opened_channel,
   output logic [DATA_W-1:0]     rsp_read_data
);

   localparam int CMP_W = (LEN_W > CNT_W) ? LEN_W + 1 : CNT_W + 1;

   // captured request
   logic [OP_W-1:0]       op_ff;
   logic [CH_FIELD_W-1:0] ch_ff;
   logic [DATA_W-1:0]     wdata_ff;
   logic                  first_ff;
   logic [LEN_W-1:0]      len_ff;

   // channel state
   logic [NUM_CHANNELS-1:0] in_use_ff, in_use_in;
   logic [PTR_W-1:0]        head_ff [NUM_CHANNELS];
   logic [PTR_W-1:0]        head_in [NUM_CHANNELS];
   logic [PTR_W-1:0]        tail_ff [NUM_CHANNELS];
   logic [PTR_W-1:0]        tail_in [NUM_CHANNELS];
   logic                    run_acc_ff, run_acc_in;

   logic [DATA_W-1:0] store [STORE_DEPTH];
   logic [DATA_W-1:0] mem_q_ff;

   // response
   logic [ST_W-1:0]       status_ff, status_in;
   logic [CH_FIELD_W-1:0] granted_ff, granted_in;
   logic                  pop_ff;

   // decode
   logic                in_range;
   logic [CH_IDX_W-1:0] c_idx;
   logic                open_ch;
   logic [PTR_W-1:0]    head_c, tail_c;
   logic [CNT_W-1:0]    used_c, free_c;
   logic [LEN_W-1:0]    len_eff;
   logic [CH_IDX_W-1:0] free_idx;
   logic                free_found;
   logic                push_en, pop_en;
   logic [ADDR_W-1:0]   push_addr, pop_addr;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      ring_next = (p == PTR_W'(CHANNEL_BYTES - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         ch_ff    <= req_channel;
         wdata_ff <= req_write_data;
         first_ff <= req_run_first;
         len_ff   <= req_run_length;
      end
   end

   assign in_range = int'(ch_ff) < NUM_CHANNELS;
   assign c_idx    = CH_IDX_W'(ch_ff);
   assign open_ch  = in_range && in_use_ff[c_idx];
   assign head_c   = head_ff[c_idx];
   assign tail_c   = tail_ff[c_idx];
   assign len_eff  = (len_ff == '0) ? LEN_W'(1) : len_ff;

   always_comb begin
      if (tail_c >= head_c) used_c = CNT_W'(tail_c) - CNT_W'(head_c);
      else used_c = CNT_W'(CHANNEL_BYTES) - CNT_W'(head_c) + CNT_W'(tail_c);
      free_c = CNT_W'(CHANNEL_BYTES - 1) - used_c;
   end

   // lowest free channel
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_idx   = CH_IDX_W'(i);
            free_found = 1'b1;
         end
      end
   end

   assign push_addr = ADDR_W'(ADDR_W'(c_idx) * ADDR_W'(CHANNEL_BYTES)) + ADDR_W'(tail_c);
   assign pop_addr  = ADDR_W'(ADDR_W'(c_idx) * ADDR_W'(CHANNEL_BYTES)) + ADDR_W'(head_c);

   always_comb begin
      in_use_in  = in_use_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      run_acc_in = run_acc_ff;
      status_in  = ST_OK;
      granted_in = '0;
      push_en    = 1'b0;
      pop_en     = 1'b0;
      case (op_ff)
         OP_OPEN: begin
            if (free_found) begin
               in_use_in[free_idx] = 1'b1;
               head_in[free_idx]   = '0;
               tail_in[free_idx]   = '0;
               granted_in          = CH_FIELD_W'(free_idx);
            end else begin
               status_in = ST_NO_CHANNEL;
            end
         end
         OP_CLOSE: begin
            if (open_ch) in_use_in[c_idx] = 1'b0;
            else         status_in        = ST_NOT_OPEN;
         end
         OP_WRITE: begin
            if (first_ff) begin
               if (!open_ch) begin
                  run_acc_in = 1'b0;
                  status_in  = ST_NOT_OPEN;
               end else if (CMP_W'(len_eff) > CMP_W'(free_c)) begin
                  run_acc_in = 1'b0;
                  status_in  = ST_NO_SPACE;
               end else begin
                  run_acc_in = 1'b1;
                  push_en    = 1'b1;
               end
            end else begin
               if (!open_ch)                         status_in = ST_NOT_OPEN;
               else if (!run_acc_ff || free_c == '0) status_in = ST_NO_SPACE;
               else                                  push_en   = 1'b1;
            end
            if (push_en) tail_in[c_idx] = ring_next(tail_c);
         end
         OP_READ: begin
            if (!open_ch) begin
               status_in = ST_NOT_OPEN;
            end else if (head_c == tail_c) begin
               status_in = ST_EMPTY;
            end else begin
               pop_en         = 1'b1;
               head_in[c_idx] = ring_next(head_c);
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff  <= '0;
         run_acc_ff <= 1'b0;
         pop_ff     <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else if (cmd.execute) begin
         in_use_ff  <= in_use_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         run_acc_ff <= run_acc_in;
         pop_ff     <= pop_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
      end
   end

   // byte store, one write or one read per word
   always_ff @(posedge clock) begin
      if (cmd.execute && push_en) store[push_addr] <= wdata_ff;
      if (cmd.execute && pop_en)  mem_q_ff         <= store[pop_addr];
   end

   assign rsp_status         = status_ff;
   assign rsp_opened_channel = granted_ff;
   assign rsp_read_data      = pop_ff ? mem_q_ff : '0;

endmodule

/* hdl/multi_channel_byte_fifo_pool_top.sv */
// ---------------------------------------------------------------------------
// multi_channel_byte_fifo_pool_top
// Pool of per-channel byte ring buffers with run-time channel allocation.
// ---------------------------------------------------------------------------
// Request stream (req_): one word per open, close, byte write or byte read.
//   tuser = op (open/close/write/read) and the first-of-run flag; tdata
//   carries channel, write byte and run length.
// Response stream (rsp_): exactly one word per request, in order.
//   tuser = status; tdata carries the granted channel and the popped byte.
// Each request is captured, executed against the channel table and the
// single-port byte store, and the response is registered. After the
// request is taken the sequencer passes through its execute state and then
// holds the response valid in its respond state; a new request is taken
// only after the capture / execute / respond sequence has finished.
// Reset frees every channel, zeroes the ring pointers and clears the run
// flag; the byte store is not cleared and no clearing pass is needed.
// While rsp_tready is low the response is held and req_tready stays low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_channel_byte_fifo_pool_top
   import mcbfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // channel[3:0], write_data[11:4], run_length[21:12]
   input  logic [2:0]  req_tuser,  // op[1:0], run_first[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // opened_channel[3:0], read_data[11:4]
   output logic [2:0]  rsp_tuser   // status[2:0]
);

   cmd_type cmd;

   logic [ST_W-1:0]       status;
   logic [CH_FIELD_W-1:0] opened;
   logic [DATA_W-1:0]     rdata;

   mcbfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mcbfp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_op             (req_tuser[1:0]),
      .req_channel        (req_tdata[3:0]),
      .req_write_data     (req_tdata[11:4]),
      .req_run_first      (req_tuser[2]),
      .req_run_length     (req_tdata[21:12]),
      .rsp_status         (status),
      .rsp_opened_channel (opened),
      .rsp_read_data      (rdata)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = {4'd0, rdata, opened};

`include "multi_channel_byte_fifo_pool_top_assert.svh"

   `MCBFP_ASSERT_NOW(a_no_overlap, clock, reset, req_tvalid && req_tready, !rsp_tvalid)
   `MCBFP_ASSERT_NEXT(a_resp_follows, clock, reset, req_tvalid && req_tready, ##1 rsp_tvalid)
   `MCBFP_ASSERT_NOW(a_data_only_ok, clock, reset, rsp_tvalid && rsp_tdata[11:4] != 8'd0, rsp_tuser == ST_OK)
   `MCBFP_ASSERT_NOW(a_grant_only_ok, clock, reset, rsp_tvalid && rsp_tdata[3:0] != 4'd0, rsp_tuser == ST_OK)

endmodule
